// ----- rtl/core/tsf_pkg.sv -----
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared constants, codes and types of the timestamped sample framer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsf_pkg;

  localparam int unsigned CONTROL_DEPTH = 1024;
  localparam int unsigned PACKET_BYTES  = 1024;

  localparam int unsigned IDX_W  = $clog2(CONTROL_DEPTH);
  localparam int unsigned PLEN_W = $clog2(PACKET_BYTES + 1);

  localparam int unsigned CNT_W   = 64;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned CTL_W   = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SPACE_W = 16;
  localparam int unsigned TAG_LSB = 8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ZERO_BYTES   = 8;
  localparam int unsigned HDR_BYTES    = 16;
  localparam int unsigned SAMPLE_BYTES = 4;
  localparam int unsigned RES_MAX      = HDR_BYTES + SAMPLE_BYTES;
  localparam int unsigned RES_W        = $clog2(RES_MAX);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_AHEAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_SPACE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_MARK_CODE   = 2'd2;

  localparam logic [SMP_W-1:0]   BEGIN_AHEAD_RST = 16'd360;
  localparam logic [SPACE_W-1:0] SPACE_LIMIT_RST = 16'd2048;
  localparam logic [CTL_W-1:0]   NO_MARK_RST     = 8'd0;

  localparam int unsigned IN_TUSER_W    = 2;
  localparam int unsigned IN_TDATA_W    = 120;
  localparam int unsigned OUT_TUSER_W   = 2;
  localparam int unsigned OUT_FIELDS_W  = 66;
  localparam int unsigned OUT_TDATA_W   = 72;

  typedef enum logic [1:0] {
    KIND_RX     = 2'd0,
    KIND_TX     = 2'd1,
    KIND_SENT   = 2'd2,
    KIND_IGNORE = 2'd3
  } item_kind_e;

  typedef enum logic [1:0] {
    OUT_RX     = 2'd0,
    OUT_BYTE   = 2'd1,
    OUT_STATUS = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE,
    BK_TXWRITE,
    BK_STATUS,
    BK_SPACE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    item_kind_e       kind;
    logic [CNT_W-1:0] rx_count;
    logic [SMP_W-1:0] rx_value;
    logic [SMP_W-1:0] rx_rssi;
    logic [SMP_W-1:0] tx_value;
    logic [CTL_W-1:0] tx_control;
  } item_t;

  typedef struct packed {
    logic [SMP_W-1:0]   begin_ahead;
    logic [SPACE_W-1:0] tx_space_limit;
    logic [CTL_W-1:0]   no_mark_code;
  } cfg_t;

  typedef struct packed {
    out_kind_e          out_kind;
    logic [BYTE_W-1:0]  packet_byte;
    logic               last;
    logic [SMP_W-1:0]   sample_out;
    logic [SMP_W-1:0]   rssi_out;
    logic [CTL_W-1:0]   control_out;
    logic [SPACE_W-1:0] space;
    logic               overflow;
    logic               tx_empty;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/tsf_ram.sv -----
// ----------------------------------------------------------------------------
// tsf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/tsf_front.sv -----
// ----------------------------------------------------------------------------
// tsf_front
// Input side: unpacks and classifies items into a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tsf_pkg::IN_TUSER_W-1:0]    in_kind_i,
  input  logic [tsf_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic                              hold_i,
  output logic                              q_valid_o,
  output tsf_pkg::item_t                    q_item_o,
  input  logic                              q_pop_i
);
  import tsf_pkg::*;

  item_t             fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  item_t             item_d;
  logic              push;
  logic              pop;

  // classification of the item kind
  always_comb begin
    item_d            = '0;
    item_d.rx_count   = in_data_i[CNT_W-1:0];
    item_d.rx_value   = in_data_i[CNT_W +: SMP_W];
    item_d.rx_rssi    = in_data_i[CNT_W+SMP_W +: SMP_W];
    item_d.tx_value   = in_data_i[CNT_W+2*SMP_W +: SMP_W];
    item_d.tx_control = in_data_i[CNT_W+3*SMP_W +: CTL_W];
    case (in_kind_i)
      KIND_RX:   item_d.kind = KIND_RX;
      KIND_TX:   item_d.kind = KIND_TX;
      KIND_SENT: item_d.kind = KIND_SENT;
      default:   item_d.kind = KIND_IGNORE;
    endcase
  end

  assign in_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH)) && !hold_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tsf_back.sv -----
// ----------------------------------------------------------------------------
// tsf_back
// Execution side: counter and packet state, control store, result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsf_pkg::cfg_t    cfg_i,
  output logic             clr_busy_o,
  input  logic             q_valid_i,
  input  tsf_pkg::item_t   q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  output tsf_pkg::result_t out_res_o,
  input  logic             out_ready_i
);
  import tsf_pkg::*;

  back_state_e       state_q;
  back_state_e       state_d;
  logic [IDX_W-1:0]  clr_addr_q;
  item_t             cur_q;
  logic [CNT_W-1:0]  tx_cnt_q;
  logic [CNT_W-1:0]  last_rx_q;
  logic [PLEN_W-1:0] plen_q;
  logic [CNT_W-1:0]  diff_q;
  logic [CNT_W-1:0]  hdr_cnt_q;
  logic [CTL_W-1:0]  ctl_q;
  logic              fit_q;
  logic [SPACE_W-1:0] space_q;
  logic              ovf_q;
  logic              empty_q;
  logic [RES_W-1:0]  idx_q;
  logic [RES_W-1:0]  end_q;
  out_kind_e         res_kind_q;
  logic              out_valid_q;
  result_t           out_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;
  logic              out_load;

  logic [PLEN_W-1:0]  plen_eff;
  logic               hdr_need;
  logic               fit;
  logic [CNT_W-1:0]   jump_cnt;
  logic               tag_hit;
  logic [CNT_W-1:0]   ahead;
  logic [SPACE_W-1:0] room;
  logic [PLEN_W-1:0]  pkt_samples;
  logic [SPACE_W-1:0] pkt_room;
  logic               ovf;
  logic [BYTE_W-1:0]  byte_sel;
  result_t            res;

  tsf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CONTROL_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // update and status arithmetic
  always_comb begin
    hdr_need    = (plen_q == '0);
    plen_eff    = hdr_need ? PLEN_W'(HDR_BYTES) : plen_q;
    fit         = ({1'b0, plen_eff} + (PLEN_W+1)'(SAMPLE_BYTES))
                  <= (PLEN_W+1)'(PACKET_BYTES);
    jump_cnt    = last_rx_q + CNT_W'(cfg_i.begin_ahead);
    tag_hit     = ram_rdata[CNT_W-1:TAG_LSB] == cur_q.rx_count[CNT_W-1:TAG_LSB];
    ahead       = diff_q[CNT_W-1] ? CNT_W'(cfg_i.begin_ahead) : diff_q;
    room        = (ahead >= CNT_W'(cfg_i.tx_space_limit)) ? '0
                  : cfg_i.tx_space_limit - ahead[SPACE_W-1:0];
    pkt_samples = (PLEN_W'(PACKET_BYTES) - plen_q) >> $clog2(SAMPLE_BYTES);
    pkt_room    = SPACE_W'(pkt_samples);
    ovf         = ({1'b0, plen_q} + (PLEN_W+1)'(SAMPLE_BYTES))
                  > (PLEN_W+1)'(PACKET_BYTES);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: begin
        if (clr_addr_q == IDX_W'(CONTROL_DEPTH - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        state_d = (cur_q.kind == KIND_TX) ? BK_TXWRITE : BK_STATUS;
      end
      BK_TXWRITE: state_d = BK_STATUS;
      BK_STATUS:  state_d = BK_SPACE;
      BK_SPACE:   state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_load && (idx_q == end_q)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = tx_cnt_q[IDX_W-1:0];
    ram_wdata  = {tx_cnt_q[CNT_W-1:TAG_LSB], cur_q.tx_control};
    ram_re     = 1'b0;
    ram_raddr  = q_item_i.rx_count[IDX_W-1:0];
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    clr_busy_o = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        clr_busy_o = 1'b1;
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
      end
      BK_IDLE: begin
        q_pop_o = q_valid_i;
        ram_re  = q_valid_i && (q_item_i.kind == KIND_RX);
      end
      BK_TXWRITE: ram_we = fit_q;
      BK_EMIT:    out_load = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  // packet byte for the current result index
  always_comb begin
    byte_sel = '0;
    if (idx_q >= RES_W'(ZERO_BYTES) && idx_q < RES_W'(HDR_BYTES)) begin
      byte_sel = BYTE_W'(hdr_cnt_q >> {idx_q[2:0], 3'b000});
    end else if (idx_q == RES_W'(HDR_BYTES)) begin
      byte_sel = cur_q.tx_value[BYTE_W-1:0];
    end else if (idx_q == RES_W'(HDR_BYTES + 1)) begin
      byte_sel = cur_q.tx_value[SMP_W-1:BYTE_W];
    end
  end

  always_comb begin
    res             = '0;
    res.out_kind    = res_kind_q;
    res.last        = (idx_q == end_q);
    res.packet_byte = (res_kind_q == OUT_BYTE) ? byte_sel : '0;
    res.sample_out  = (res_kind_q == OUT_RX) ? cur_q.rx_value : '0;
    res.rssi_out    = (res_kind_q == OUT_RX) ? cur_q.rx_rssi : '0;
    res.control_out = (res_kind_q == OUT_RX) ? ctl_q : '0;
    res.space       = space_q;
    res.overflow    = ovf_q;
    res.tx_empty    = empty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_addr_q  <= '0;
      tx_cnt_q    <= '0;
      last_rx_q   <= '0;
      plen_q      <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_CLEAR: clr_addr_q <= clr_addr_q + 1'b1;
        BK_UPDATE: begin
          idx_q <= '0;
          end_q <= '0;
          case (cur_q.kind)
            KIND_RX: last_rx_q <= cur_q.rx_count;
            KIND_TX: begin
              if (diff_q[CNT_W-1]) begin
                tx_cnt_q <= jump_cnt;
              end
              plen_q <= fit ? plen_eff + PLEN_W'(SAMPLE_BYTES) : plen_eff;
              if (hdr_need || fit) begin
                idx_q <= hdr_need ? '0 : RES_W'(HDR_BYTES);
                end_q <= fit ? RES_W'(RES_MAX - 1) : RES_W'(HDR_BYTES - 1);
              end
            end
            KIND_SENT: plen_q <= '0;
            default: begin
            end
          endcase
        end
        BK_TXWRITE: begin
          if (fit_q) begin
            tx_cnt_q <= tx_cnt_q + 1'b1;
          end
        end
        BK_EMIT: begin
          if (out_load) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        cur_q  <= q_item_i;
        diff_q <= tx_cnt_q - last_rx_q;
      end
      BK_UPDATE: begin
        ctl_q <= tag_hit ? ram_rdata[CTL_W-1:0] : cfg_i.no_mark_code;
        fit_q <= fit;
        case (cur_q.kind)
          KIND_RX: res_kind_q <= OUT_RX;
          KIND_TX: res_kind_q <= (hdr_need || fit) ? OUT_BYTE : OUT_STATUS;
          default: res_kind_q <= OUT_STATUS;
        endcase
      end
      BK_TXWRITE: hdr_cnt_q <= tx_cnt_q;
      BK_STATUS:  diff_q    <= tx_cnt_q - last_rx_q;
      BK_SPACE: begin
        space_q <= (room < pkt_room) ? room : pkt_room;
        ovf_q   <= ovf;
        empty_q <= diff_q[CNT_W-1];
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/timestamped_sample_framer.sv -----
// ----------------------------------------------------------------------------
// timestamped_sample_framer
// Frames transmit samples against received sample counts.
//
// Input stream: tuser carries the item kind (receive sample, transmit sample,
// packet sent); tdata carries the sample fields. Output stream: one transfer
// per result, tuser gives the result kind, tlast marks the final result of
// an input item. Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i,
// by the user only while the block is idle; the block does not enforce this.
// Accepted items enter a two-entry queue; the back end takes one item at a
// time. A receive, packet-sent or ignored item passes the idle, update, status,
// space and emit states. A transmit sample adds a control store write state and
// emits a status result or its packet bytes, twenty when it opens a packet; the
// byte sequencer, one result per cycle while the receiver is ready, sets the rate.
// After reset the control store is cleared, one entry per cycle over all 1024
// entries, with s_axis_tready low; counters and packet length reset to zero.
// When the receiver stalls, the output register holds its transfer, the back
// end waits, and the queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_sample_framer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // rx_count, rx_value, rx_rssi, tx_value, tx_control
  input  logic [tsf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // kind
  input  logic [tsf_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // packet_byte, sample_out, rssi_out, control_out, space, overflow,
  // tx_empty, zero fill
  output logic [tsf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // out_kind
  output logic [tsf_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import tsf_pkg::*;

  cfg_t    cfg_q;
  logic    clr_busy;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.begin_ahead    <= BEGIN_AHEAD_RST;
      cfg_q.tx_space_limit <= SPACE_LIMIT_RST;
      cfg_q.no_mark_code   <= NO_MARK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BEGIN_AHEAD:    cfg_q.begin_ahead    <= cfg_wdata_i;
        CFG_TX_SPACE_LIMIT: cfg_q.tx_space_limit <= cfg_wdata_i;
        CFG_NO_MARK_CODE:   cfg_q.no_mark_code   <= cfg_wdata_i[CTL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .hold_i     (clr_busy),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  tsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clr_busy_o  (clr_busy),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, res.tx_empty, res.overflow,
                         res.space, res.control_out, res.rssi_out, res.sample_out,
                         res.packet_byte};
  assign m_axis_tuser = res.out_kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
